FILE: hw/rtl/bpra_pkg.sv
package bpra_pkg;

  localparam int MAX_PAGES  = 256;
  localparam int PAGE_SHIFT = 12;                  // 4096-byte pages
  localparam int ROW_BITS   = 8;                   // map bits per memory row
  localparam int ROW_SH     = $clog2(ROW_BITS);
  localparam int ROWS       = MAX_PAGES / ROW_BITS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int CNT_W      = 9;

  localparam logic [31:0]      WINDOW_BASE  = 32'hC000_0000;
  localparam logic [31:0]      WINDOW_END   = 32'hFFFF_FFFE;
  localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(200);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;
  localparam logic [1:0] ST_NOTUSED = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                rd_en;
    logic [ROW_W-1:0]    rd_row;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_BITS-1:0] wr_data;
    logic                clear;
  } map_req_t;

  // Managed page count, clamped to the map size.
  function automatic logic [CNT_W-1:0] eff_pages(input logic [CNT_W-1:0] a);
    if (a > CNT_W'(MAX_PAGES)) begin
      return CNT_W'(MAX_PAGES);
    end
    return a;
  endfunction

endpackage

FILE: hw/rtl/bitmap_page_range_allocator_unit.sv
// Channel  | Handshake               | Word
// ---------+-------------------------+------------------------------------------
// request  | in_valid / in_ready     | mode, page_count, address
// result   | out_valid / out_ready   | result_address, status, free_pages
// config   | cfg_wr_en (no wait)     | cfg_wr_data = active_pages
//
// One request at a time. Allocate: accept, scan one map row (8 pages) per cycle
// until a fit is found (up to 32 rows), mark each row of the run, then post.
// Free: read the row, clear the page's bit if set, post. Rejected requests go straight to posting.
// Marking is a read-modify-write of each row over the registered map read.
// Reset (rst, synchronous) and every config write clear the map at once through
// row valid bits. A stalled result parks the engine in its posting state, in_ready low.
module bitmap_page_range_allocator_unit
  import bpra_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             mode,
  input  logic [CNT_W-1:0] page_count,
  input  logic [31:0]      address,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      result_address,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] free_pages,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_MARK_RD = 3'd2;
  localparam logic [2:0] S_MARK_WR = 3'd3;
  localparam logic [2:0] S_FREE    = 3'd4;
  localparam logic [2:0] S_PUSH    = 3'd5;

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    eff, free_count;
  logic [CNT_W-1:0]    req_count;
  logic [ROW_W-1:0]    proc_row;
  logic [CNT_W-1:0]    run;
  logic [ROW_W-1:0]    mark_row;
  logic [IDX_W-1:0]    mark_start, mark_end;
  logic [ROW_SH-1:0]   free_bit;
  logic [ROW_W-1:0]    free_row;
  logic [31:0]         res_addr;
  logic [1:0]          res_status;

  map_req_t            map_req;
  logic [ROW_BITS-1:0] map_rd;

  // scan step over one row
  logic [CNT_W-1:0]    run_v;
  logic                found_v;
  logic [CNT_W-1:0]    start_v, end_v;
  logic [ROW_W:0]      nrows;
  logic                last_row;

  // free address decode
  logic [31:0]         off;
  logic [31-PAGE_SHIFT:0] fidx;
  logic                addr_bad;

  logic [ROW_BITS-1:0] mark_mask;
  logic                accept;
  logic                push_ok;

  bpra_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (map_rd)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign push_ok  = !out_valid || out_ready;

  assign nrows    = (ROW_W+1)'((eff + CNT_W'(ROW_BITS - 1)) >> ROW_SH);
  assign last_row = ({1'b0, proc_row} + 1'b1) >= nrows;

  assign off      = address - WINDOW_BASE;
  assign fidx     = off[31:PAGE_SHIFT];
  assign addr_bad = (address[PAGE_SHIFT-1:0] != '0) || (address < WINDOW_BASE) ||
                    (address >= WINDOW_END) ||
                    (fidx >= (32-PAGE_SHIFT)'(eff));

  // First-fit step across the eight pages of the row just read.
  always_comb begin
    logic [CNT_W-1:0] i_v;
    run_v   = run;
    found_v = 1'b0;
    start_v = '0;
    end_v   = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      i_v = CNT_W'({proc_row, ROW_SH'(j)});
      if (!found_v) begin
        if (!map_rd[j] && (i_v < eff)) begin
          run_v = run_v + 1'b1;
          if (run_v == req_count) begin
            found_v = 1'b1;
            start_v = i_v + 1'b1 - req_count;
            end_v   = i_v;
          end
        end else begin
          run_v = '0;
        end
      end
    end
  end

  always_comb begin
    logic [IDX_W-1:0] k_v;
    for (int j = 0; j < ROW_BITS; j++) begin
      k_v          = {mark_row, ROW_SH'(j)};
      mark_mask[j] = (k_v >= mark_start) && (k_v <= mark_end);
    end
  end

  // Map port control.
  always_comb begin
    map_req        = '0;
    map_req.clear  = cfg_wr_en;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_ALLOC) begin
            if (page_count == '0 || page_count > free_count) begin
              state_next = S_PUSH;
            end else begin
              map_req.rd_en  = 1'b1;
              map_req.rd_row = '0;
              state_next     = S_SCAN;
            end
          end else if (addr_bad) begin
            state_next = S_PUSH;
          end else begin
            map_req.rd_en  = 1'b1;
            map_req.rd_row = fidx[IDX_W-1:ROW_SH];
            state_next     = S_FREE;
          end
        end
      end
      S_SCAN: begin
        map_req.rd_en  = 1'b1;
        map_req.rd_row = proc_row + 1'b1;
        if (found_v) begin
          state_next = S_MARK_RD;
        end else if (last_row) begin
          state_next = S_PUSH;
        end
      end
      S_MARK_RD: begin
        map_req.rd_en  = 1'b1;
        map_req.rd_row = mark_row;
        state_next     = S_MARK_WR;
      end
      S_MARK_WR: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_row  = mark_row;
        map_req.wr_data = map_rd | mark_mask;
        state_next      = (mark_row == mark_end[IDX_W-1:ROW_SH]) ? S_PUSH : S_MARK_RD;
      end
      S_FREE: begin
        if (map_rd[free_bit]) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_row  = free_row;
          map_req.wr_data = map_rd & ~(ROW_BITS'(1) << free_bit);
        end
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (push_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eff        <= ACTIVE_RESET;
      free_count <= ACTIVE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        eff        <= eff_pages(cfg_wr_data);
        free_count <= eff_pages(cfg_wr_data);
      end else if (state == S_SCAN && found_v) begin
        free_count <= free_count - req_count;
      end else if (state == S_FREE && map_rd[free_bit]) begin
        free_count <= free_count + 1'b1;
      end
      if (state == S_PUSH && push_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_count  <= page_count;
          proc_row   <= '0;
          run        <= '0;
          free_row   <= fidx[IDX_W-1:ROW_SH];
          free_bit   <= fidx[ROW_SH-1:0];
          res_addr   <= '0;
          res_status <= (mode == MODE_ALLOC) ? ST_NOSPACE : ST_BADADDR;
        end
      end
      S_SCAN: begin
        run      <= run_v;
        proc_row <= proc_row + 1'b1;
        if (found_v) begin
          mark_start <= start_v[IDX_W-1:0];
          mark_end   <= end_v[IDX_W-1:0];
          mark_row   <= start_v[IDX_W-1:ROW_SH];
          res_addr   <= WINDOW_BASE + (32'(start_v) << PAGE_SHIFT);
          res_status <= ST_OK;
        end
      end
      S_MARK_WR: begin
        mark_row <= mark_row + 1'b1;
      end
      S_FREE: begin
        res_status <= map_rd[free_bit] ? ST_OK : ST_NOTUSED;
      end
      S_PUSH: begin
        if (push_ok) begin
          result_address <= res_addr;
          status         <= res_status;
          free_pages     <= free_count;
        end
      end
      default: begin
      end
    endcase
  end

  // The free count never runs past the managed page count.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= eff)
    else $error("free count exceeds managed pages");

  // A zero-page allocate goes straight to posting a failure.
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_ALLOC && page_count == '0) |=> state == S_PUSH)
    else $error("zero-page allocate did not fail at once");

  // Marking never walks past the last row of the run.
  a_mark_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK_WR) |-> mark_row <= mark_end[IDX_W-1:ROW_SH])
    else $error("mark pass overran the run");

  // Any successful result carries a page-aligned address.
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK) |-> result_address[PAGE_SHIFT-1:0] == '0)
    else $error("unaligned result address");

endmodule

FILE: hw/rtl/bpra_map.sv
// Occupancy map: registered read, per-row valid bits make a cleared
// row read as all free.
module bpra_map
  import bpra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  map_req_t            req,
  output logic [ROW_BITS-1:0] rd_data
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] rd_q;
  logic                rd_vq;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q  <= mem[req.rd_row];
      rd_vq <= row_valid[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_row] <= 1'b1;
    end
  end

  assign rd_data = rd_vq ? rd_q : '0;

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpra_pkg::*;

  // One result word per request: what the allocator should hand back.
  typedef struct {
    logic [31:0]      addr;
    logic [1:0]       st;
    logic [CNT_W-1:0] free_n;
  } alloc_outcome_t;

  // Shadow of the occupancy map plus the queue of outcomes still owed by the block.
  class page_alloc_scoreboard;
    bit               page_used[MAX_PAGES];
    logic [CNT_W-1:0] active_cfg;
    logic [CNT_W-1:0] free_cnt;
    alloc_outcome_t   expected_outcomes[$];
    int               errors;

    function int managed();
      return (active_cfg > CNT_W'(MAX_PAGES)) ? MAX_PAGES : int'(active_cfg);
    endfunction

    // Register write (and reset): wipe the map, reload the free count.
    function void load_active(logic [CNT_W-1:0] v);
      active_cfg = v;
      foreach (page_used[i]) page_used[i] = 1'b0;
      free_cnt = CNT_W'(managed());
    endfunction

    // Lowest-indexed run of 'want' free pages among the managed ones.
    function bit first_fit(int want, output int start);
      int run;
      run   = 0;
      start = 0;
      for (int i = 0; i < managed(); i++) begin
        if (!page_used[i]) begin
          run++;
          if (run == want) begin
            start = i + 1 - want;
            return 1'b1;
          end
        end else begin
          run = 0;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic m, logic [CNT_W-1:0] cnt, logic [31:0] addr);
      alloc_outcome_t o;
      int             start;
      int             idx;
      bit             fits;
      o.addr = '0;
      o.st   = ST_OK;
      fits   = 1'b0;
      if (m == MODE_ALLOC) begin
        if (cnt != 0 && cnt <= free_cnt) fits = first_fit(int'(cnt), start);
        if (!fits) begin
          o.st = ST_NOSPACE;
        end else begin
          for (int k = 0; k < int'(cnt); k++) page_used[start + k] = 1'b1;
          free_cnt -= cnt;
          o.addr = WINDOW_BASE + (32'(start) << PAGE_SHIFT);
        end
      end else begin
        idx = int'((addr - WINDOW_BASE) >> PAGE_SHIFT);
        if (addr[PAGE_SHIFT-1:0] != '0 || addr < WINDOW_BASE || addr >= WINDOW_END ||
            idx >= managed()) begin
          o.st = ST_BADADDR;
        end else if (!page_used[idx]) begin
          o.st = ST_NOTUSED;
        end else begin
          page_used[idx] = 1'b0;
          free_cnt++;
        end
      end
      o.free_n = free_cnt;
      expected_outcomes.push_back(o);
    endfunction

    function void check_result(logic [31:0] a, logic [1:0] s, logic [CNT_W-1:0] f);
      alloc_outcome_t o;
      if (expected_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing outstanding: addr %h status %0d free %0d",
                 $time, a, s, f);
        return;
      end
      o = expected_outcomes.pop_front();
      if (a !== o.addr) begin
        errors++;
        $display("%0t: result_address expected %h actual %h", $time, o.addr, a);
      end
      if (s !== o.st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, o.st, s);
      end
      if (f !== o.free_n) begin
        errors++;
        $display("%0t: free_pages expected %0d actual %0d", $time, o.free_n, f);
      end
    endfunction

    function int random_used_page();
      int busy[$];
      for (int i = 0; i < MAX_PAGES; i++) if (page_used[i]) busy.push_back(i);
      if (busy.size() == 0) return -1;
      return busy[$urandom_range(busy.size() - 1)];
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             mode = MODE_ALLOC;
  logic [CNT_W-1:0] page_count = '0;
  logic [31:0]      address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [31:0]      result_address;
  logic [1:0]       status;
  logic [CNT_W-1:0] free_pages;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  page_alloc_scoreboard alloc_sb;
  bit                   steady = 1'b0;   // no idling on either side while set

  // Random phases: managed page count and request words per phase.
  // Slot 5 draws its page count at random.
  int phase_active[8] = '{256, 1, 511, 0, 13, 0, 200, 64};
  int phase_words[8]  = '{260, 120, 300, 40, 200, 200, 230, 200};

  bitmap_page_range_allocator_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .page_count     (page_count),
    .address        (address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_address (result_address),
    .status         (status),
    .free_pages     (free_pages),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: back-pressure about 12% of cycles, none during the steady stretch.
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 12);
    end
  end

  // Every result word accepted is checked against the oldest outstanding outcome.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      alloc_sb.check_result(result_address, status, free_pages);
    end
  end

  function automatic logic [31:0] page_addr(int idx);
    return WINDOW_BASE + (32'(idx) << PAGE_SHIFT);
  endfunction

  // Present one request word and hold it until the block takes it.
  task automatic send_request(input logic m, input logic [CNT_W-1:0] cnt,
                              input logic [31:0] addr);
    if (!steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    page_count <= cnt;
    address    <= addr;
    do @(posedge clk); while (!in_ready);
    alloc_sb.note_request(m, cnt, addr);
  endtask

  task automatic release_bus();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (alloc_sb.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the engine idle; the spare clocks after the
  // last result let it leave its posting state.
  task automatic write_active(input logic [CNT_W-1:0] v);
    release_bus();
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alloc_sb.load_active(v);
  endtask

  // Mostly well-formed traffic: small allocations and frees of pages in use,
  // with some junk addresses and odd counts mixed in.
  task automatic random_request();
    int               r;
    int               pick;
    int               pg;
    int               lim;
    logic [CNT_W-1:0] cnt;
    logic [31:0]      addr;
    lim = alloc_sb.managed();
    r   = $urandom_range(99);
    // nearly full map: lean toward frees so allocations keep succeeding
    if (alloc_sb.free_cnt * 4 < lim && r < 40) r += 40;
    cnt  = CNT_W'($urandom);   // ignored field of a free still carries noise
    addr = $urandom;           // same for an allocate
    if (r < 40) begin
      pick = $urandom_range(19);
      if (pick < 15) begin
        cnt = CNT_W'($urandom_range(1, 4));
      end else if (pick < 18) begin
        cnt = CNT_W'($urandom_range(1, (lim > 0) ? lim : 1));
      end else if (pick == 18) begin
        cnt = '0;
      end
      send_request(MODE_ALLOC, cnt, addr);
    end else if (r < 85) begin
      pg = alloc_sb.random_used_page();
      if (pg < 0) pg = $urandom_range(MAX_PAGES - 1);
      send_request(MODE_FREE, cnt, page_addr(pg));
    end else begin
      case ($urandom_range(3))
        0: ;  // fully random address
        1: addr = WINDOW_BASE + (($urandom & 32'h3FFFF) << PAGE_SHIFT);
        2: addr = page_addr($urandom_range(MAX_PAGES - 1)) | 32'($urandom_range(1, 4095));
        default: addr = page_addr($urandom_range(MAX_PAGES - 1));
      endcase
      send_request(MODE_FREE, cnt, addr);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] act;
    alloc_sb = new();
    alloc_sb.load_active(ACTIVE_RESET);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 200 managed pages after reset.
    send_request(MODE_ALLOC, '0, 32'hFFFF_FFFF);     // zero count
    send_request(MODE_FREE, 9'h1FF, page_addr(0));   // page never allocated
    send_request(MODE_ALLOC, 9'd1, '0);
    send_request(MODE_ALLOC, 9'd8, '0);
    send_request(MODE_ALLOC, 9'd256, '0);            // more than free
    send_request(MODE_ALLOC, 9'h1FF, '0);
    send_request(MODE_FREE, '0, 32'hC000_0001);      // unaligned
    send_request(MODE_FREE, '0, 32'hBFFF_F000);      // below window
    send_request(MODE_FREE, '0, WINDOW_END);         // top of window
    send_request(MODE_FREE, '0, 32'h0000_0000);
    send_request(MODE_FREE, '0, page_addr(200));     // first page past managed
    send_request(MODE_FREE, '0, page_addr(199));     // last managed, unused
    send_request(MODE_FREE, '0, page_addr(0));
    send_request(MODE_ALLOC, 9'd1, '0);              // reuses page 0
    send_request(MODE_FREE, '0, page_addr(4));       // single-page hole
    send_request(MODE_ALLOC, 9'd2, '0);              // skips the hole
    send_request(MODE_ALLOC, 9'd1, '0);              // fills the hole
    send_request(MODE_FREE, '0, page_addr(5));
    send_request(MODE_ALLOC, 9'd190, '0);            // enough free, no run long enough
    send_request(MODE_ALLOC, 9'd189, '0);
    send_request(MODE_ALLOC, 9'd1, '0);              // last free page
    send_request(MODE_ALLOC, 9'd1, '0);              // map full
    write_active('0);                                // nothing managed
    send_request(MODE_ALLOC, 9'd1, '0);
    send_request(MODE_FREE, '0, page_addr(0));
    write_active(9'h1FF);                            // clamps to the map size
    send_request(MODE_ALLOC, 9'd256, '0);
    send_request(MODE_FREE, '0, page_addr(255));

    // Random phases across page-count settings.
    for (int p = 0; p < 8; p++) begin
      act = (p == 5) ? CNT_W'($urandom_range(1, 256)) : CNT_W'(phase_active[p]);
      write_active(act);
      steady = (p == 2);
      for (int n = 0; n < phase_words[p]; n++) begin
        // hold off once until the block has answered everything sent so far
        if (p == 0 && n == 130) begin
          release_bus();
          wait_drained();
        end
        random_request();
      end
    end
    steady = 1'b0;

    release_bus();
    wait_drained();
    repeat (120) @(posedge clk);
    if (alloc_sb.errors == 0 && alloc_sb.expected_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bpra_pkg.sv
hw/rtl/bpra_map.sv
hw/rtl/bitmap_page_range_allocator_unit.sv
tb/tb.sv
